// ----- hw/rtl/raster_position_to_rom_address_unit_defines.svh -----
// Assertion macros shared by the RTL files of the raster address unit.
// The asserting module must have clk and arst_n in scope.
`ifndef RASTER_POSITION_TO_ROM_ADDRESS_UNIT_DEFINES_SVH
`define RASTER_POSITION_TO_ROM_ADDRESS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RPTRA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rptra assertion failed");
`define RPTRA_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("rptra forbidden condition seen");
`else
`define RPTRA_ASSERT(lbl, prop)
`define RPTRA_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ----- hw/rtl/rptra_pkg.sv -----
package rptra_pkg;

	localparam int RowW  = 10;
	localparam int ColW  = 6;
	localparam int AddrW = 16;

	// Column and row limits of the raster timing.
	localparam logic [ColW-1:0]  HTotalCol     = 6'd57;
	localparam logic [ColW-1:0]  HActiveCol    = 6'd32;
	localparam logic [ColW-1:0]  IntWidthCol   = 6'd15;
	localparam logic [ColW-1:0]  HsStartCol    = 6'd41;
	localparam logic [ColW-1:0]  HsEndCol      = 6'd48;
	localparam logic [ColW-1:0]  MarkBeforeCol = 6'd40;
	localparam logic [ColW-1:0]  MarkAfterCol  = 6'd48;
	localparam logic [RowW:0]    VTotalRow     = 11'd525;
	localparam logic [RowW-1:0]  VActiveRow    = 10'd384;
	localparam logic [RowW-1:0]  IntRow        = 10'd453;
	localparam logic [RowW-1:0]  VsStartRow    = 10'd454;
	localparam logic [RowW-1:0]  VsEndRow      = 10'd456;

	// Region bases, flags and strides of the address map.
	localparam logic [AddrW-1:0] OddBank       = 16'h2000;
	localparam logic [AddrW-1:0] HBorderBase   = 16'h4000;
	localparam logic [AddrW-1:0] VBorderBase   = 16'h8000;
	localparam logic [AddrW-1:0] SyncBase      = 16'hc000;
	localparam logic [AddrW-1:0] IntBase       = 16'hc800;
	localparam logic [AddrW-1:0] AfterOffset   = 16'h0400;
	localparam logic [AddrW-1:0] HsFlag        = 16'h1000;
	localparam logic [AddrW-1:0] VsFlag        = 16'h2000;
	localparam logic [AddrW-1:0] HsStride      = 16'd7;
	localparam logic [AddrW-1:0] HBorderStride = 16'd25;
	localparam logic [AddrW-1:0] VStride       = 16'd57;
	localparam int               ActColBits    = 5;

	// Bit swap masks.
	localparam logic [AddrW-1:0] SwapKeep      = 16'hf81f;
	localparam logic [AddrW-1:0] SwapLow       = 16'h00e0;
	localparam logic [AddrW-1:0] SwapHigh      = 16'h0700;

	typedef struct packed {
		logic [ColW-1:0] column;
		logic [RowW-1:0] row;
	} pos_t;

	function automatic logic [AddrW-1:0] swap_fields(input logic [AddrW-1:0] a);
		return (a & SwapKeep) | ((a >> 3) & SwapLow) | ((a << 3) & SwapHigh);
	endfunction

endpackage

// ----- hw/rtl/raster_position_to_rom_address_unit.sv -----
// An accepted position is held in the input register (pos_s1); its address is then
// written to the result register (addr_s2), which drives m_tdata.
// Throughput: one transaction per cycle, held back only by m_tready.
// The address is computed between the input register and the result register.
// Reset (arst_n low, asynchronous) empties both registers; data is not cleared.
`include "raster_position_to_rom_address_unit_defines.svh"

module raster_position_to_rom_address_unit
	import rptra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // row [9:0], column [15:10]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [AddrW-1:0] m_tdata    // rom_address [15:0]
);

	pos_t             pos_s1;
	logic             valid_s1;
	logic [AddrW-1:0] addr_s2;
	logic             valid_s2;
	logic [AddrW-1:0] map_addr;
	logic             adv_s2;
	logic             s_accept;

	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign s_accept = s_tvalid && s_tready;

	rptra_map u_map (
		.pos         (pos_s1),
		.rom_address (map_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !adv_s2);
			valid_s2 <= adv_s2 || (valid_s2 && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pos_s1 <= pos_t'(s_tdata);
		end
		if (adv_s2) begin
			addr_s2 <= map_addr;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = addr_s2;

	`RPTRA_ASSERT(a_load_s1, s_tvalid && s_tready |=> valid_s1)
	`RPTRA_ASSERT(a_move_s2, adv_s2 |=> valid_s2)
	`RPTRA_ASSERT(a_full_stall, valid_s1 && valid_s2 && !m_tready |-> !s_tready)
	`RPTRA_ASSERT(a_stay_empty, !valid_s1 && !(s_tvalid && s_tready) |=> !valid_s1)
	`RPTRA_ASSERT_NEVER(a_no_overrun, valid_s1 && !adv_s2 && s_accept)

endmodule

// ----- hw/rtl/rptra_map.sv -----
module rptra_map
	import rptra_pkg::*;
(
	input  pos_t             pos,
	output logic [AddrW-1:0] rom_address
);

	logic [RowW:0]    row_inc;
	logic [RowW-1:0]  r;
	logic [ColW-1:0]  c;
	logic [AddrW-1:0] r16;
	logic [AddrW-1:0] c16;
	logic [AddrW-1:0] addr;
	logic             in_hs;
	logic             in_vs;

	always_comb begin
		row_inc = {1'b0, pos.row} + (RowW+1)'(1);
		if (pos.column >= HTotalCol) begin
			c = '0;
			r = (row_inc >= VTotalRow) ? '0 : row_inc[RowW-1:0];
		end else begin
			c = pos.column;
			r = pos.row;
		end

		r16   = AddrW'(r);
		c16   = AddrW'(c);
		in_hs = (c >= HsStartCol) && (c < HsEndCol);
		in_vs = (r >= VsStartRow) && (r < VsEndRow);

		priority if (r < VActiveRow && c < HActiveCol) begin
			addr = AddrW'({r[RowW-1:1], c[ActColBits-1:0]}) | (r[0] ? OddBank : '0);
		end else if (r == IntRow && c < IntWidthCol) begin
			addr = IntBase + c16;
		end else if (in_hs) begin
			addr = SyncBase | (in_vs ? VsFlag : '0)
				| (HsFlag + r16 * HsStride + (c16 - AddrW'(HsStartCol)));
		end else if (in_vs) begin
			addr = SyncBase | (VsFlag + (r16 - AddrW'(VsStartRow)) * VStride + c16);
		end else if (c == MarkBeforeCol) begin
			addr = SyncBase + r16;
		end else if (c == MarkAfterCol) begin
			addr = SyncBase + r16 + AfterOffset;
		end else if (r < VActiveRow) begin
			addr = HBorderBase + r16 * HBorderStride + (c16 - AddrW'(HActiveCol));
		end else begin
			addr = VBorderBase + (r16 - AddrW'(VActiveRow)) * VStride + c16;
		end

		rom_address = swap_fields(addr);
	end

endmodule
